### rtl/ita_pkg.sv
package ita_pkg;

  // default sizes
  localparam int ENTRY_COUNT_DEF        = 16;
  localparam int BLOCK_TOTAL_DEF        = 128;
  localparam int POINTERS_PER_ENTRY_DEF = 8;

  // operation codes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_XLATE  = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_NO_ENTRY   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_BAD_BLOCK  = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd5;
  localparam logic [2:0] ST_LIST_EMPTY = 3'd6;

  // what a result carries besides its status
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_XLATE = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       free_inc;
    logic       ent_latch;
    logic       got_clr;
    logic       alloc_bit;
    logic       commit;
    logic       rd_ent;
    logic       size_latch;
    logic       used_clr;
    logic       rd_dptr;
    logic       free_bit;
    logic       rd_tptr;
    logic       out_load;
    logic [1:0] out_kind;
    logic [2:0] out_status;
  } ita_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       too_large;
    logic       no_space;
    logic       blk_last;
    logic       blk_free;
    logic       ent_last;
    logic       ent_used;
    logic       name_match;
    logic       bad_block;
    logic       got_done;
    logic       none_used;
    logic       list_last;
    logic       out_free;
  } ita_sts_t;

endpackage

### rtl/ita_ram.sv
module ita_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ita_ctrl.sv
module ita_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ita_pkg::ita_sts_t  sts,
  output ita_pkg::ita_cmd_t  cmd
);
  import ita_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_ESCAN = 4'd4;
  localparam logic [3:0] S_ALLOC = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCMP  = 4'd7;
  localparam logic [3:0] S_DFRD  = 4'd8;
  localparam logic [3:0] S_DFWR  = 4'd9;
  localparam logic [3:0] S_TRD   = 4'd10;
  localparam logic [3:0] S_LSCAN = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] code_r, code_nxt;
  logic [1:0] kind_r, kind_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    code_nxt  = code_r;
    kind_nxt  = kind_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.cnt_clr = 1'b1;
        kind_nxt    = KIND_PLAIN;
        case (sts.mode)
          MODE_CREATE: begin
            if (sts.too_large) begin
              code_nxt  = ST_TOO_LARGE;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_CNT;
            end
          end
          MODE_DELETE, MODE_XLATE: state_nxt = S_FRD;
          default: begin
            if (sts.none_used) begin
              code_nxt  = ST_LIST_EMPTY;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_LSCAN;
            end
          end
        endcase
      end
      // count free blocks
      S_CNT: begin
        cmd.free_inc = sts.blk_free;
        if (sts.blk_last) begin
          state_nxt = S_CHK;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_CHK: begin
        cmd.cnt_clr = 1'b1;
        if (sts.no_space) begin
          code_nxt  = ST_NO_SPACE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ESCAN;
        end
      end
      // first free entry
      S_ESCAN: begin
        if (!sts.ent_used) begin
          cmd.ent_latch = 1'b1;
          cmd.cnt_clr   = 1'b1;
          cmd.got_clr   = 1'b1;
          state_nxt     = S_ALLOC;
        end else if (sts.ent_last) begin
          code_nxt  = ST_NO_ENTRY;
          state_nxt = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      // hand out the lowest free blocks
      S_ALLOC: begin
        if (sts.got_done) begin
          cmd.commit = 1'b1;
          code_nxt   = ST_OK;
          state_nxt  = S_OUT;
        end else begin
          cmd.cnt_inc   = 1'b1;
          cmd.alloc_bit = sts.blk_free;
        end
      end
      // name lookup
      S_FRD: begin
        cmd.rd_ent = 1'b1;
        state_nxt  = S_FCMP;
      end
      S_FCMP: begin
        if (sts.name_match) begin
          cmd.ent_latch  = 1'b1;
          cmd.size_latch = 1'b1;
          cmd.got_clr    = 1'b1;
          if (sts.mode == MODE_DELETE) begin
            cmd.used_clr = 1'b1;
            state_nxt    = S_DFRD;
          end else if (sts.bad_block) begin
            code_nxt  = ST_BAD_BLOCK;
            state_nxt = S_OUT;
          end else begin
            cmd.rd_tptr = 1'b1;
            state_nxt   = S_TRD;
          end
        end else if (sts.ent_last) begin
          code_nxt  = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FRD;
        end
      end
      // release the blocks of a deleted entry
      S_DFRD: begin
        if (sts.got_done) begin
          code_nxt  = ST_OK;
          state_nxt = S_OUT;
        end else begin
          cmd.rd_dptr = 1'b1;
          state_nxt   = S_DFWR;
        end
      end
      S_DFWR: begin
        cmd.free_bit = 1'b1;
        state_nxt    = S_DFRD;
      end
      S_TRD: begin
        code_nxt  = ST_OK;
        kind_nxt  = KIND_XLATE;
        state_nxt = S_OUT;
      end
      // walk used entries
      S_LSCAN: begin
        if (sts.ent_used) begin
          cmd.rd_ent = 1'b1;
          code_nxt   = ST_OK;
          kind_nxt   = KIND_LIST;
          state_nxt  = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      // result transfer into the output register
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (kind_r == KIND_LIST && !sts.list_last) begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_LSCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.out_kind   = kind_r;
    cmd.out_status = code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
      kind_r  <= KIND_PLAIN;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

### rtl/ita_dp.sv
module ita_dp #(
  parameter int ENTRY_COUNT        = ita_pkg::ENTRY_COUNT_DEF,
  parameter int BLOCK_TOTAL        = ita_pkg::BLOCK_TOTAL_DEF,
  parameter int POINTERS_PER_ENTRY = ita_pkg::POINTERS_PER_ENTRY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ita_pkg::ita_cmd_t  cmd,
  output ita_pkg::ita_sts_t  sts,
  input  logic [1:0]         in_mode,
  input  logic [63:0]        in_name_high,
  input  logic [63:0]        in_name_low,
  input  logic [3:0]         in_block_count,
  input  logic [2:0]         in_block_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [6:0]         out_block_index,
  output logic [63:0]        out_entry_name_high,
  output logic [63:0]        out_entry_name_low,
  output logic [3:0]         out_entry_size,
  output logic               out_last
);
  import ita_pkg::*;

  localparam int PTR_W  = $clog2(BLOCK_TOTAL);
  localparam int CNT_BW = $clog2(BLOCK_TOTAL + 1);
  localparam int CNT_EW = $clog2(ENTRY_COUNT + 1);
  localparam int CW     = (CNT_BW > CNT_EW) ? CNT_BW : CNT_EW;
  localparam int EI     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int GW     = $clog2(POINTERS_PER_ENTRY + 1);
  localparam int PDEPTH = ENTRY_COUNT * POINTERS_PER_ENTRY;
  localparam int AW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int XW     = AW + 4;
  localparam logic [4:0]    P5       = 5'(POINTERS_PER_ENTRY);
  localparam logic [XW-1:0] PX       = XW'(POINTERS_PER_ENTRY);
  localparam logic [CW-1:0] BLK_LAST = CW'(BLOCK_TOTAL - 1);
  localparam logic [CW-1:0] ENT_LAST = CW'(ENTRY_COUNT - 1);
  localparam logic [PTR_W:0] BLK_LIM = (PTR_W + 1)'(BLOCK_TOTAL);

  logic [1:0]             mode_r;
  logic [63:0]            nh_r, nl_r;
  logic [3:0]             bcnt_r;
  logic [2:0]             bnum_r;
  logic [CW-1:0]          cnt_r, free_r;
  logic [GW-1:0]          got_r;
  logic [EI-1:0]          ent_r;
  logic [3:0]             size_r;
  logic [BLOCK_TOTAL-1:0] bitmap_r;
  logic [ENTRY_COUNT-1:0] used_r;
  logic                   out_valid_r;

  logic [EI-1:0]    cidx;
  logic [PTR_W-1:0] bidx;
  logic [63:0]      hi_rd, lo_rd;
  logic [3:0]       size_rd;
  logic [PTR_W-1:0] ptr_rd;
  logic [XW-1:0]    wr_x, dr_x, tr_x;
  logic [AW-1:0]    p_waddr, p_raddr;
  logic [3:0]       got_target;
  logic             list_last;
  logic [PTR_W+6:0] ptr_ext;

  assign cidx = cnt_r[EI-1:0];
  assign bidx = cnt_r[PTR_W-1:0];

  // pointer store addresses: entry times pointers plus slot
  assign wr_x    = XW'(ent_r) * PX + XW'(got_r);
  assign dr_x    = wr_x;
  assign tr_x    = XW'(cidx) * PX + XW'(bnum_r);
  assign p_waddr = wr_x[AW-1:0];
  assign p_raddr = cmd.rd_tptr ? tr_x[AW-1:0] : dr_x[AW-1:0];

  ita_ram #(.WIDTH(64), .DEPTH(ENTRY_COUNT)) u_name_hi (
    .clk, .we(cmd.commit), .waddr(ent_r), .wdata(nh_r),
    .re(cmd.rd_ent), .raddr(cidx), .rdata(hi_rd)
  );
  ita_ram #(.WIDTH(64), .DEPTH(ENTRY_COUNT)) u_name_lo (
    .clk, .we(cmd.commit), .waddr(ent_r), .wdata(nl_r),
    .re(cmd.rd_ent), .raddr(cidx), .rdata(lo_rd)
  );
  ita_ram #(.WIDTH(4), .DEPTH(ENTRY_COUNT)) u_size (
    .clk, .we(cmd.commit), .waddr(ent_r), .wdata(bcnt_r),
    .re(cmd.rd_ent), .raddr(cidx), .rdata(size_rd)
  );
  ita_ram #(.WIDTH(PTR_W), .DEPTH(PDEPTH)) u_ptr (
    .clk, .we(cmd.alloc_bit), .waddr(p_waddr), .wdata(bidx),
    .re(cmd.rd_dptr | cmd.rd_tptr), .raddr(p_raddr), .rdata(ptr_rd)
  );

  // no used entry above the scan position
  always_comb begin
    list_last = 1'b1;
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      if (used_r[k] && CW'(k) > cnt_r) begin
        list_last = 1'b0;
      end
    end
  end

  assign got_target = (mode_r == MODE_CREATE) ? bcnt_r : size_r;
  assign ptr_ext    = {7'd0, ptr_rd};

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.mode       = mode_r;
    sts.too_large  = {1'b0, bcnt_r} > P5;
    sts.no_space   = free_r < CW'(bcnt_r);
    sts.blk_last   = cnt_r == BLK_LAST;
    sts.blk_free   = !bitmap_r[bidx];
    sts.ent_last   = cnt_r == ENT_LAST;
    sts.ent_used   = used_r[cidx];
    sts.name_match = used_r[cidx] && hi_rd == nh_r && lo_rd == nl_r;
    sts.bad_block  = ({1'b0, bnum_r} >= size_rd) || ({2'b0, bnum_r} >= P5);
    sts.got_done   = 5'(got_r) == {1'b0, got_target};
    sts.none_used  = used_r == '0;
    sts.list_last  = list_last;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // input item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      nh_r   <= in_name_high;
      nl_r   <= in_name_low;
      bcnt_r <= in_block_count;
      bnum_r <= in_block_number;
    end
  end

  // scan counters and latched entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      free_r <= '0;
      got_r  <= '0;
      ent_r  <= '0;
      size_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r  <= '0;
        free_r <= '0;
      end else begin
        if (cmd.cnt_inc) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (cmd.free_inc) begin
          free_r <= free_r + 1'b1;
        end
      end
      if (cmd.got_clr) begin
        got_r <= '0;
      end else if (cmd.alloc_bit || cmd.rd_dptr) begin
        got_r <= got_r + 1'b1;
      end
      if (cmd.ent_latch) begin
        ent_r <= cidx;
      end
      if (cmd.size_latch) begin
        size_r <= size_rd;
      end
    end
  end

  // block bitmap and entry used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      used_r   <= '0;
    end else begin
      if (cmd.alloc_bit) begin
        bitmap_r[bidx] <= 1'b1;
      end
      if (cmd.free_bit && {1'b0, ptr_rd} < BLK_LIM) begin
        bitmap_r[ptr_rd] <= 1'b0;
      end
      if (cmd.commit) begin
        used_r[ent_r] <= 1'b1;
      end
      if (cmd.used_clr) begin
        used_r[cidx] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status          <= cmd.out_status;
      out_block_index     <= (cmd.out_kind == KIND_XLATE) ? ptr_ext[6:0] : 7'd0;
      out_entry_name_high <= (cmd.out_kind == KIND_LIST) ? hi_rd : 64'd0;
      out_entry_name_low  <= (cmd.out_kind == KIND_LIST) ? lo_rd : 64'd0;
      out_entry_size      <= (cmd.out_kind == KIND_LIST) ? size_rd : 4'd0;
      out_last            <= (cmd.out_kind == KIND_LIST) ? list_last : 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/inode_table_block_allocator.sv
// Flat-file block allocator: a free-block bitmap plus a table of named file entries,
// driven by create, delete, translate and list requests, one request at a time.
// Create counts free blocks over the whole bitmap, then scans for the first free
// entry and then hands out the lowest free blocks; delete and translate search the
// entries one by one, with a read and a compare per entry, and delete then releases
// its blocks one by one; list scans the entries and gives one result per used entry.
// The work is done by sequential bitmap and entry scans through the entry stores.
// A pending result waits in the output register.
module inode_table_block_allocator #(
  parameter int ENTRY_COUNT        = ita_pkg::ENTRY_COUNT_DEF,
  parameter int BLOCK_TOTAL        = ita_pkg::BLOCK_TOTAL_DEF,
  parameter int POINTERS_PER_ENTRY = ita_pkg::POINTERS_PER_ENTRY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_name_high,
  input  logic [63:0] in_name_low,
  input  logic [3:0]  in_block_count,
  input  logic [2:0]  in_block_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [6:0]  out_block_index,
  output logic [63:0] out_entry_name_high,
  output logic [63:0] out_entry_name_low,
  output logic [3:0]  out_entry_size,
  output logic        out_last
);
  import ita_pkg::*;

  ita_cmd_t cmd;
  ita_sts_t sts;

  ita_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .sts, .cmd
  );

  ita_dp #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .BLOCK_TOTAL(BLOCK_TOTAL),
    .POINTERS_PER_ENTRY(POINTERS_PER_ENTRY)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode, .in_name_high, .in_name_low, .in_block_count, .in_block_number,
    .out_valid, .out_stall, .out_status, .out_block_index,
    .out_entry_name_high, .out_entry_name_low, .out_entry_size, .out_last
  );

  // only list results may leave last low, and those are ok
  a_not_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_status == ST_OK)
    else $error("non-final result without ok status");

  // an empty list is always a final result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_LIST_EMPTY) |-> out_last)
    else $error("list empty result not final");

  // no new item is taken while a result is being loaded
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> in_stall)
    else $error("result loaded while input open");

  // a fresh load always raises valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

### tb/tb_inode_table_block_allocator.sv
`timescale 1ns / 1ps

module tb_inode_table_block_allocator;
  import ita_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_BLOCKS  = 128;
  localparam int PTRS        = 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  block_index;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [3:0]  size;
    logic        last;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [63:0] in_name_high;
  logic [63:0] in_name_low;
  logic [3:0]  in_block_count;
  logic [2:0]  in_block_number;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [6:0]  out_block_index;
  logic [63:0] out_entry_name_high;
  logic [63:0] out_entry_name_low;
  logic [3:0]  out_entry_size;
  logic        out_last;

  // predictor state
  logic        blk_busy [NUM_BLOCKS];
  logic        ent_valid [NUM_ENTRIES];
  logic [63:0] ent_hi [NUM_ENTRIES];
  logic [63:0] ent_lo [NUM_ENTRIES];
  logic [3:0]  ent_size [NUM_ENTRIES];
  logic [6:0]  ent_ptr [NUM_ENTRIES][PTRS];

  alloc_result_t pending_results[$];
  int          error_count;
  longint      cycle_count;
  logic        hold_off;

  // names used by the random part, so lookups hit often
  logic [63:0] pool_hi [6];
  logic [63:0] pool_lo [6];

  inode_table_block_allocator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_name_high        (in_name_high),
    .in_name_low         (in_name_low),
    .in_block_count      (in_block_count),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_block_index     (out_block_index),
    .out_entry_name_high (out_entry_name_high),
    .out_entry_name_low  (out_entry_name_low),
    .out_entry_size      (out_entry_size),
    .out_last            (out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic alloc_result_t plain_result(logic [2:0] st);
    alloc_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int lookup_entry(logic [63:0] nh, logic [63:0] nl);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (ent_valid[i] && ent_hi[i] == nh && ent_lo[i] == nl) return i;
    return -1;
  endfunction

  // compute expected results of one request and update the table
  task automatic predict_request(logic [1:0] mode, logic [63:0] nh, logic [63:0] nl,
                                 logic [3:0] cnt, logic [2:0] bnum);
    int free_cnt;
    int slot;
    int got;
    int last_pos;
    alloc_result_t r;
    free_cnt = 0;
    slot = -1;
    got = 0;
    last_pos = -1;
    case (mode)
      MODE_CREATE: begin
        for (int i = 0; i < NUM_BLOCKS; i++) if (!blk_busy[i]) free_cnt++;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) if (!ent_valid[i]) slot = i;
        if (cnt > PTRS) pending_results.push_back(plain_result(ST_TOO_LARGE));
        else if (free_cnt < cnt) pending_results.push_back(plain_result(ST_NO_SPACE));
        else if (slot < 0) pending_results.push_back(plain_result(ST_NO_ENTRY));
        else begin
          for (int i = 0; i < NUM_BLOCKS && got < cnt; i++)
            if (!blk_busy[i]) begin
              blk_busy[i] = 1'b1;
              ent_ptr[slot][got] = i[6:0];
              got++;
            end
          ent_hi[slot] = nh;
          ent_lo[slot] = nl;
          ent_size[slot] = cnt;
          ent_valid[slot] = 1'b1;
          pending_results.push_back(plain_result(ST_OK));
        end
      end
      MODE_DELETE: begin
        slot = lookup_entry(nh, nl);
        if (slot < 0) pending_results.push_back(plain_result(ST_NOT_FOUND));
        else begin
          ent_valid[slot] = 1'b0;
          for (int j = 0; j < ent_size[slot]; j++) blk_busy[ent_ptr[slot][j]] = 1'b0;
          pending_results.push_back(plain_result(ST_OK));
        end
      end
      MODE_XLATE: begin
        slot = lookup_entry(nh, nl);
        if (slot < 0) pending_results.push_back(plain_result(ST_NOT_FOUND));
        else if (bnum >= ent_size[slot]) pending_results.push_back(plain_result(ST_BAD_BLOCK));
        else begin
          r = plain_result(ST_OK);
          r.block_index = ent_ptr[slot][bnum];
          pending_results.push_back(r);
        end
      end
      default: begin
        for (int i = 0; i < NUM_ENTRIES; i++) if (ent_valid[i]) last_pos = i;
        if (last_pos < 0) pending_results.push_back(plain_result(ST_LIST_EMPTY));
        else
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (ent_valid[i]) begin
              r = '0;
              r.status = ST_OK;
              r.name_high = ent_hi[i];
              r.name_low = ent_lo[i];
              r.size = ent_size[i];
              r.last = (i == last_pos);
              pending_results.push_back(r);
            end
      end
    endcase
  endtask

  // offer one request, wait for its transfer
  task automatic send_request(logic [1:0] mode, logic [63:0] nh, logic [63:0] nl,
                              logic [3:0] cnt, logic [2:0] bnum, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13)));
    // valid drops at the previous transfer edge, so move past it first
    repeat (gap + 1) @(posedge clk);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_name_high    <= nh;
    in_name_low     <= nl;
    in_block_count  <= cnt;
    in_block_number <= bnum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(mode, nh, nl, cnt, bnum);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (out_valid && !out_stall) out_stall <= ($urandom_range(0, 2) == 0) ? 1'b0 :
                                                   ($urandom_range(0, 13) != 0);
    else if (out_stall) out_stall <= ($urandom_range(0, 13) != 0);
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_block_index !== want.block_index) begin
          $display("%0t: block_index exp %0d got %0d", $time, want.block_index,
                   out_block_index);
          error_count++;
        end
        if (out_entry_name_high !== want.name_high) begin
          $display("%0t: name_high exp %h got %h", $time, want.name_high,
                   out_entry_name_high);
          error_count++;
        end
        if (out_entry_name_low !== want.name_low) begin
          $display("%0t: name_low exp %h got %h", $time, want.name_low, out_entry_name_low);
          error_count++;
        end
        if (out_entry_size !== want.size) begin
          $display("%0t: size exp %0d got %0d", $time, want.size, out_entry_size);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_inode_table_block_allocator failed");
      $finish;
    end
  end

  // directed: extremes, every operation and every status except no space
  task automatic test_directed();
    send_request(MODE_LIST, '0, '0, 4'd0, 3'd0);
    send_request(MODE_CREATE, '1, '1, 4'd15, 3'd7);
    send_request(MODE_CREATE, '1, '1, 4'd9, 3'd0);
    send_request(MODE_CREATE, '1, '1, 4'd8, 3'd0);
    send_request(MODE_CREATE, '0, '0, 4'd0, 3'd0);
    send_request(MODE_CREATE, 64'h4142_0000_0000_0000, '0, 4'd3, 3'd0);
    send_request(MODE_CREATE, 64'h4142_0000_0000_0000, 64'h1, 4'd5, 3'd0);
    send_request(MODE_XLATE, '1, '1, 4'd0, 3'd7);
    send_request(MODE_XLATE, '1, '1, 4'd0, 3'd0);
    send_request(MODE_XLATE, '0, '0, 4'd0, 3'd0);
    send_request(MODE_XLATE, 64'h4142_0000_0000_0000, '0, 4'd0, 3'd3);
    send_request(MODE_XLATE, 64'h1234, '0, 4'd0, 3'd0);
    send_request(MODE_LIST, '0, '0, 4'd0, 3'd0);
    send_request(MODE_DELETE, '1, '1, 4'd0, 3'd0);
    send_request(MODE_DELETE, '1, '1, 4'd0, 3'd0);
    send_request(MODE_CREATE, 64'h5555, 64'haaaa, 4'd4, 3'd0);
    send_request(MODE_XLATE, 64'h5555, 64'haaaa, 4'd0, 3'd2);
    // fill the table to reach the no entry case
    for (int i = 0; i < 13; i++) send_request(MODE_CREATE, 64'h100 + i, 64'h0, 4'd0, 3'd0);
    send_request(MODE_CREATE, 64'h200, '0, 4'd0, 3'd0);
    send_request(MODE_LIST, '0, '0, 4'd0, 3'd0);
    wait_drained();
  endtask

  // no space: a full table of big files exhausts blocks
  task automatic test_no_space();
    for (int i = 0; i < 13; i++) send_request(MODE_DELETE, 64'h100 + i, 64'h0, 4'd0, 3'd0);
    // empty the table so sixteen full files take every block
    send_request(MODE_DELETE, 64'h5555, 64'haaaa, 4'd0, 3'd0);
    send_request(MODE_DELETE, '0, '0, 4'd0, 3'd0);
    send_request(MODE_DELETE, 64'h4142_0000_0000_0000, '0, 4'd0, 3'd0);
    send_request(MODE_DELETE, 64'h4142_0000_0000_0000, 64'h1, 4'd0, 3'd0);
    for (int i = 0; i < 16; i++) send_request(MODE_CREATE, 64'h300 + i, '1, 4'd8, 3'd0, 1);
    send_request(MODE_CREATE, 64'h3ff, '0, 4'd1, 3'd0);
    send_request(MODE_DELETE, 64'h300, '1, 4'd0, 3'd0);
    send_request(MODE_DELETE, 64'h301, '1, 4'd0, 3'd0);
    send_request(MODE_CREATE, 64'h400, '0, 4'd8, 3'd0);
    wait_drained();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_request(MODE_LIST, '0, '0, 4'd0, 3'd0, 1);
    join
    wait_drained();
  endtask

  // random mix over a small name pool, with occasional random names
  task automatic test_random();
    int k;
    logic [1:0]  mode;
    logic [63:0] nh;
    logic [63:0] nl;
    for (int i = 0; i < 6; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    for (int n = 0; n < 35; n++) begin
      k = int'($urandom_range(0, 5));
      nh = pool_hi[k];
      nl = pool_lo[k];
      if ($urandom_range(0, 9) == 0) begin
        nh = {$urandom, $urandom};
        nl = {$urandom, $urandom};
      end
      mode = 2'($urandom_range(0, 3));
      send_request(mode, nh, nl,
                   ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8)),
                   3'($urandom_range(0, 7)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_name_high = '0;
    in_name_low = '0;
    in_block_count = '0;
    in_block_number = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    error_count = 0;
    cycle_count = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) blk_busy[i] = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_size[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_space();
    test_backpressure();
    test_random();
    if (error_count == 0 && pending_results.size() == 0)
      $display("tb_inode_table_block_allocator passed");
    else
      $display("tb_inode_table_block_allocator failed");
    $finish;
  end

endmodule
